// ----- hdl/mcpt_pkg.sv -----
// Shared types and constants for the periodic timer table.
// Used by mcpt_cell and the top level; no dependencies.
package mcpt_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int OCC_W       = $clog2(TIMER_SLOTS + 1);
  localparam logic [31:0] FAR_LIMIT = 32'd2000000000;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_CHECK = 3'd2,
    OP_TICK  = 3'd3,
    OP_SHIFT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_INVALID   = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  client;
    logic [15:0] timer;
    logic [30:0] period;
    logic [31:0] last_fire;
    logic [15:0] limit;
    logic [15:0] count;
  } slot_t;

  // Commands from the sequencer to every cell of the row.
  typedef struct packed {
    logic        rotate;   // whole row shifts one place toward cell 0
    logic        load_tail;
    logic        shift;    // add offset to every last-fire time
    logic [31:0] offset;
  } row_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TICK, S_PAD, S_OUT
  } state_t;

endpackage

// ----- hdl/mcpt_cell.sv -----
// One storage cell of the timer row: holds one slot word.
// Depends on mcpt_pkg.
module mcpt_cell
  import mcpt_pkg::*;
(
  input  logic     clk,
  input  row_ctl_t ctl,
  input  slot_t    from_next,
  input  slot_t    tail_word,
  input  logic     is_tail,
  output slot_t    word
);

  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      word <= from_next;
    end else if (ctl.load_tail && is_tail) begin
      word <= tail_word;
    end else if (ctl.shift) begin
      word.last_fire <= word.last_fire + ctl.offset;
    end
  end

endmodule

// ----- hdl/multi_channel_periodic_timer_table_core.sv -----
// Periodic timer table: a ring of TIMER_SLOTS cells that rotates through cell 0.
// Start, stop and check rotate the live row once.
// Tick rotates it once, holding on output stalls; shift and unknown ops do not.
// Each tick result leaves as it is made; a stall holds the rotation.
// Reset (rst, synchronous) empties the table and idles the handshake; slot contents
// are not cleared and are never read before written.
module multi_channel_periodic_timer_table_core
  import mcpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [31:0] now_ms,
  input  logic [7:0]  client,
  input  logic [15:0] timer_id,
  input  logic signed [31:0] delay_ms,
  input  logic signed [31:0] period_ms,
  input  logic [15:0] max_fires,
  input  logic signed [31:0] shift_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  status,
  output logic        is_on,
  output logic [7:0]  fired_client,
  output logic [15:0] fired_timer,
  output logic [15:0] fire_count,
  output logic        last
);

  // Row and its wiring. Rotation: cell i takes cell i+1; the top cell of the
  // live part takes the (possibly updated) head word. A dropped head simply
  // falls past the shortened live part.
  slot_t    cells [TIMER_SLOTS];
  slot_t    head_upd;
  slot_t    tail_word;
  row_ctl_t ctl;
  logic [OCC_W-1:0] occupied, occupied_next;
  logic [OCC_W-1:0] tail_pos;

  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_row
      slot_t nxt;
      if (g == TIMER_SLOTS - 1) begin : g_top
        assign nxt = head_upd;
      end else begin : g_mid
        assign nxt = (OCC_W'(g + 1) == tail_pos) ? head_upd : cells[g + 1];
      end
      mcpt_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .from_next(nxt),
        .tail_word(tail_word),
        .is_tail  (tail_pos == OCC_W'(g)),
        .word     (cells[g])
      );
    end
  endgenerate

  // Latched command word.
  op_t         op_r;
  logic [31:0] now_r;
  logic [7:0]  cl_r;
  logic [15:0] tm_r;
  logic [31:0] delay_r, period_r, shift_r;
  logic [15:0] lim_r;

  state_t state, state_next;
  logic [OCC_W-1:0] cnt, cnt_next;     // words still to visit
  logic [OCC_W-1:0] live, live_next;   // current row length during a pass
  logic found, found_next;
  logic [2:0] st_hold, st_hold_next;
  logic on_hold, on_hold_next;

  // Output register.
  logic        ov, ov_next;
  kind_t       k_r, k_next;
  logic [2:0]  s_r, s_next;
  logic        on_r, on_next;
  logic [7:0]  fc_r, fc_next;
  logic [15:0] ft_r, ft_next;
  logic [15:0] cn_r, cn_next;
  logic        l_r, l_next;

  assign kind = k_r;
  assign status = s_r;
  assign is_on = on_r;
  assign fired_client = fc_r;
  assign fired_timer = ft_r;
  assign fire_count = cn_r;
  assign last = l_r;
  assign out_valid = ov;
  assign in_stall = (state != S_IDLE) || (ov && out_stall);

  wire accept = in_valid && !in_stall;
  wire out_free = !ov || !out_stall;

  // Tick evaluation of the head word.
  slot_t h;
  logic [31:0] lf, gap;
  logic ahead, due, done_lim;
  slot_t tick_word;
  always_comb begin
    h = cells[0];
    gap = (now_r < h.last_fire) ? h.last_fire - now_r : now_r - h.last_fire;
    lf = (gap > FAR_LIMIT) ? now_r : h.last_fire;
    ahead = now_r < lf;
    due = !ahead && ((now_r - lf) >= {1'b0, h.period});
    tick_word = h;
    tick_word.last_fire = (ahead || due) ? now_r : lf;
    if (due) tick_word.count = h.count + 16'd1;
    done_lim = due && (h.limit != 16'd0) && (tick_word.count == h.limit);
  end

  wire match = (h.client == cl_r) && (h.timer == tm_r);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    live_next = live;
    found_next = found;
    st_hold_next = st_hold;
    on_hold_next = on_hold;
    occupied_next = occupied;
    ctl = '0;
    ctl.offset = shift_r;
    head_upd = h;
    tail_pos = live;
    tail_word.client = cl_r;
    tail_word.timer = tm_r;
    tail_word.period = period_r[30:0];
    tail_word.last_fire = now_r + delay_r - period_r;
    tail_word.limit = lim_r;
    tail_word.count = 16'd0;
    ov_next = ov && out_stall;
    k_next = k_r; s_next = s_r; on_next = on_r;
    fc_next = fc_r; ft_next = ft_r; cn_next = cn_r; l_next = l_r;

    case (state)
      S_IDLE: begin
        if (accept) begin
          cnt_next = occupied;
          live_next = occupied;
          found_next = 1'b0;
          case (op_t'(operation))
            OP_START, OP_STOP, OP_CHECK: state_next = S_SCAN;
            OP_TICK:  state_next = S_TICK;
            OP_SHIFT: begin
              st_hold_next = ST_OK; on_hold_next = 1'b0;
              state_next = S_PAD;
            end
            default: begin
              st_hold_next = ST_INVALID; on_hold_next = 1'b0;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_PAD: begin
        ctl.shift = 1'b1;
        state_next = S_OUT;
      end
      S_SCAN: begin
        if (cnt != '0) begin
          ctl.rotate = 1'b1;
          cnt_next = cnt - 1'b1;
          if (match) begin
            found_next = 1'b1;
            if (op_r == OP_STOP) begin
              live_next = live - 1'b1;
            end
          end
        end else begin
          state_next = S_OUT;
          on_hold_next = 1'b0;
          st_hold_next = ST_OK;
          case (op_r)
            OP_STOP: begin
              on_hold_next = found;
              st_hold_next = found ? ST_OK : ST_NOT_FOUND;
              occupied_next = live;
            end
            OP_CHECK: on_hold_next = found;
            default: begin
              if (occupied >= OCC_W'(TIMER_SLOTS)) st_hold_next = ST_FULL;
              else if (cl_r == 8'd0 || delay_r[31] || period_r == 32'd0 || period_r[31])
                st_hold_next = ST_INVALID;
              else if (found) st_hold_next = ST_DUPLICATE;
              else begin
                ctl.load_tail = 1'b1;
                tail_pos = occupied;
                occupied_next = occupied + 1'b1;
              end
            end
          endcase
        end
      end
      S_TICK: begin
        if (out_free) begin
          if (cnt != '0) begin
            ctl.rotate = 1'b1;
            head_upd = tick_word;
            cnt_next = cnt - 1'b1;
            if (done_lim) begin
              live_next = live - 1'b1;
            end
            if (due) begin
              ov_next = 1'b1; k_next = KIND_FIRED; s_next = ST_OK; on_next = 1'b0;
              fc_next = h.client; ft_next = h.timer; cn_next = tick_word.count;
              l_next = 1'b0;
            end
          end else begin
            occupied_next = live;
            ov_next = 1'b1; k_next = KIND_DONE; s_next = ST_OK; on_next = 1'b0;
            fc_next = '0; ft_next = '0; cn_next = '0; l_next = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_next = 1'b1; k_next = KIND_STATUS; s_next = st_hold; on_next = on_hold;
          fc_next = '0; ft_next = '0; cn_next = '0; l_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occupied <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      occupied <= occupied_next;
      ov <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next; live <= live_next; found <= found_next;
    st_hold <= st_hold_next; on_hold <= on_hold_next;
    k_r <= k_next; s_r <= s_next; on_r <= on_next;
    fc_r <= fc_next; ft_r <= ft_next; cn_r <= cn_next; l_r <= l_next;
    if (accept) begin
      op_r <= op_t'(operation); now_r <= now_ms; cl_r <= client; tm_r <= timer_id;
      delay_r <= delay_ms; period_r <= period_ms; lim_r <= max_fires; shift_r <= shift_ms;
    end
  end

  // Table never holds more than its slot count.
  a_occ: assert property (@(posedge clk) disable iff (rst)
    occupied <= OCC_W'(TIMER_SLOTS)) else $error("occupancy overflow");
  // No word is taken while a pass is running.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  // An accepted word always leaves the idle state.
  a_go: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE)) else $error("accepted word dropped");

endmodule
